// ===== hdl/rgb888_pixel_format_converter_unit_defines.svh =====
// assertion macros shared by the pixel format converter rtl
`ifndef RGB888_PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH
`define RGB888_PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/rpfc_pkg.sv =====
// shared types and constants of the pixel format converter
package rpfc_pkg;

   // field widths
   localparam int SRC_W   = 24;
   localparam int PIX_W   = 32;
   localparam int CHAN_W  = 16;
   localparam int SHIFT_W = 5;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // per-channel scaling tables: one entry per 8-bit source value
   localparam int TBL_AW    = 8;
   localparam int TBL_DEPTH = 256;

   // register indexes
   localparam logic [2:0] REG_RED_MAX     = 3'd0;
   localparam logic [2:0] REG_GREEN_MAX   = 3'd1;
   localparam logic [2:0] REG_BLUE_MAX    = 3'd2;
   localparam logic [2:0] REG_RED_SHIFT   = 3'd3;
   localparam logic [2:0] REG_GREEN_SHIFT = 3'd4;
   localparam logic [2:0] REG_BLUE_SHIFT  = 3'd5;
   localparam logic [2:0] REG_PIXEL_SIZE  = 3'd6;
   localparam logic [2:0] REG_SWAP_BYTES  = 3'd7;

   // pixel size codes
   localparam logic [1:0] PIX_SIZE_8  = 2'd0;
   localparam logic [1:0] PIX_SIZE_16 = 2'd1;
   localparam logic [1:0] PIX_SIZE_32 = 2'd2;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [CHAN_W-1:0]  red_max;
      logic [CHAN_W-1:0]  green_max;
      logic [CHAN_W-1:0]  blue_max;
      logic [SHIFT_W-1:0] red_shift;
      logic [SHIFT_W-1:0] green_shift;
      logic [SHIFT_W-1:0] blue_shift;
      logic [1:0]         pixel_size;
      logic               swap_bytes;
   } cfg_type;

   // table write from the fill unit, all three channels at one address
   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } tbl_wr_type;

endpackage

// ===== hdl/rpfc_ram.sv =====
// generic simple dual-port ram with registered read
module rpfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, output holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rpfc_csr.sv =====
// apb register file holding the target pixel format
module rpfc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rpfc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rpfc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rpfc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output rpfc_pkg::cfg_type           cfg,
   output logic                        max_wr
);

   rpfc_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_acc;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_acc     = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   // register update on the access phase of a write
   always_comb begin
      cfg_in = cfg_ff;
      max_wr = 1'b0;
      if (wr_acc) begin
         case (reg_idx)
            rpfc_pkg::REG_RED_MAX: begin
               cfg_in.red_max = csr_pwdata[rpfc_pkg::CHAN_W-1:0];
               max_wr         = 1'b1;
            end
            rpfc_pkg::REG_GREEN_MAX: begin
               cfg_in.green_max = csr_pwdata[rpfc_pkg::CHAN_W-1:0];
               max_wr           = 1'b1;
            end
            rpfc_pkg::REG_BLUE_MAX: begin
               cfg_in.blue_max = csr_pwdata[rpfc_pkg::CHAN_W-1:0];
               max_wr          = 1'b1;
            end
            rpfc_pkg::REG_RED_SHIFT: begin
               cfg_in.red_shift = csr_pwdata[rpfc_pkg::SHIFT_W-1:0];
            end
            rpfc_pkg::REG_GREEN_SHIFT: begin
               cfg_in.green_shift = csr_pwdata[rpfc_pkg::SHIFT_W-1:0];
            end
            rpfc_pkg::REG_BLUE_SHIFT: begin
               cfg_in.blue_shift = csr_pwdata[rpfc_pkg::SHIFT_W-1:0];
            end
            rpfc_pkg::REG_PIXEL_SIZE: begin
               cfg_in.pixel_size = csr_pwdata[1:0];
            end
            rpfc_pkg::REG_SWAP_BYTES: begin
               cfg_in.swap_bytes = csr_pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // reset to 24-bit true colour, little endian
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_max     <= rpfc_pkg::CHAN_W'(255);
         cfg_ff.green_max   <= rpfc_pkg::CHAN_W'(255);
         cfg_ff.blue_max    <= rpfc_pkg::CHAN_W'(255);
         cfg_ff.red_shift   <= rpfc_pkg::SHIFT_W'(16);
         cfg_ff.green_shift <= rpfc_pkg::SHIFT_W'(8);
         cfg_ff.blue_shift  <= rpfc_pkg::SHIFT_W'(0);
         cfg_ff.pixel_size  <= rpfc_pkg::PIX_SIZE_32;
         cfg_ff.swap_bytes  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         rpfc_pkg::REG_RED_MAX:     csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.red_max);
         rpfc_pkg::REG_GREEN_MAX:   csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.green_max);
         rpfc_pkg::REG_BLUE_MAX:    csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.blue_max);
         rpfc_pkg::REG_RED_SHIFT:   csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.red_shift);
         rpfc_pkg::REG_GREEN_SHIFT: csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.green_shift);
         rpfc_pkg::REG_BLUE_SHIFT:  csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.blue_shift);
         rpfc_pkg::REG_PIXEL_SIZE:  csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.pixel_size);
         rpfc_pkg::REG_SWAP_BYTES:  csr_prdata = rpfc_pkg::CSR_DW'(cfg_ff.swap_bytes);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/rpfc_fill.sv =====
// sweep unit that rebuilds the three channel scaling tables
module rpfc_fill (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 max_wr,
   input  rpfc_pkg::cfg_type    cfg,
   output rpfc_pkg::tbl_wr_type tbl_wr,
   output logic                 busy
);

   localparam int PROD_W = rpfc_pkg::CHAN_W + rpfc_pkg::TBL_AW;
   localparam int EST_W  = PROD_W + 17;
   localparam logic [PROD_W-1:0] RoundBias = PROD_W'(127);
   localparam logic [PROD_W-1:0] ChanFull  = PROD_W'(255);

   logic                        run_ff, run_in;
   logic [rpfc_pkg::TBL_AW-1:0] cnt_ff, cnt_in;
   logic                        m_v_ff, q_v_ff;
   logic [rpfc_pkg::TBL_AW-1:0] m_addr_ff, q_addr_ff;
   logic [PROD_W-1:0]           m_x_ff [3];
   logic [PROD_W-1:0]           m_x_in [3];
   logic [PROD_W-1:0]           q_x_ff [3];
   logic [rpfc_pkg::CHAN_W-1:0] q_est_ff [3];
   logic [rpfc_pkg::CHAN_W-1:0] q_est_in [3];
   logic [rpfc_pkg::CHAN_W-1:0] max_sel [3];
   logic [EST_W-1:0]            est_sum [3];
   logic [PROD_W-1:0]           rem [3];
   logic [rpfc_pkg::CHAN_W-1:0] quo [3];

   assign max_sel[0] = cfg.red_max;
   assign max_sel[1] = cfg.green_max;
   assign max_sel[2] = cfg.blue_max;

   // address sweep, restarted by any write to a channel maximum
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (max_wr) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + rpfc_pkg::TBL_AW'(1);
         if (cnt_ff == '1) begin
            run_in = 1'b0;
         end
      end
   end

   // per lane: product plus rounding, then reciprocal estimate of x/255
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_x_in[i]   = PROD_W'(cnt_ff) * PROD_W'(max_sel[i]) + RoundBias;
         est_sum[i]  = EST_W'(m_x_ff[i]) + (EST_W'(m_x_ff[i]) << 8)
                     + (EST_W'(m_x_ff[i]) << 16);
         q_est_in[i] = est_sum[i][PROD_W +: rpfc_pkg::CHAN_W];
      end
   end

   // correction: estimate is the quotient or one short of it
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem[i] = q_x_ff[i] - {q_est_ff[i], 8'h00} + PROD_W'(q_est_ff[i]);
         quo[i] = (rem[i] >= ChanFull) ? q_est_ff[i] + rpfc_pkg::CHAN_W'(1)
                                       : q_est_ff[i];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
         m_v_ff <= 1'b0;
         q_v_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         m_v_ff <= run_ff;
         q_v_ff <= m_v_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      m_addr_ff <= cnt_ff;
      q_addr_ff <= m_addr_ff;
      for (int i = 0; i < 3; i++) begin
         m_x_ff[i]   <= m_x_in[i];
         q_x_ff[i]   <= m_x_ff[i];
         q_est_ff[i] <= q_est_in[i];
      end
   end

   assign tbl_wr.en    = q_v_ff;
   assign tbl_wr.addr  = q_addr_ff;
   assign tbl_wr.red   = quo[0];
   assign tbl_wr.green = quo[1];
   assign tbl_wr.blue  = quo[2];

   assign busy = run_ff | m_v_ff | q_v_ff;

endmodule

// ===== hdl/rpfc_pixel.sv =====
// pixel assembly and output register
module rpfc_pixel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rpfc_pkg::CHAN_W-1:0] red_val,
   input  logic [rpfc_pkg::CHAN_W-1:0] green_val,
   input  logic [rpfc_pkg::CHAN_W-1:0] blue_val,
   input  rpfc_pkg::cfg_type           cfg,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rpfc_pkg::PIX_W-1:0]  rsp_tdata
);

   logic                       out_v_ff, out_v_in;
   logic [rpfc_pkg::PIX_W-1:0] out_d_ff;
   logic [rpfc_pkg::PIX_W-1:0] placed;
   logic [rpfc_pkg::PIX_W-1:0] pix_in;
   logic                       take;

   assign in_ready = ~out_v_ff | rsp_tready;
   assign take     = in_valid & in_ready;

   // place channels, bits above 32 fall away
   assign placed = (rpfc_pkg::PIX_W'(red_val) << cfg.red_shift)
                 | (rpfc_pkg::PIX_W'(green_val) << cfg.green_shift)
                 | (rpfc_pkg::PIX_W'(blue_val) << cfg.blue_shift);

   // truncate to pixel size and optionally reverse bytes
   always_comb begin
      case (cfg.pixel_size)
         rpfc_pkg::PIX_SIZE_8: begin
            pix_in = {24'h000000, placed[7:0]};
         end
         rpfc_pkg::PIX_SIZE_16: begin
            pix_in = cfg.swap_bytes ? {16'h0000, placed[7:0], placed[15:8]}
                                    : {16'h0000, placed[15:0]};
         end
         rpfc_pkg::PIX_SIZE_32: begin
            pix_in = cfg.swap_bytes
                   ? {placed[7:0], placed[15:8], placed[23:16], placed[31:24]}
                   : placed;
         end
         default: begin
            pix_in = '0;
         end
      endcase
   end

   // output register valid
   always_comb begin
      out_v_in = out_v_ff;
      if (take) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_d_ff <= pix_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule

// ===== hdl/rgb888_pixel_format_converter_unit.sv =====
// top level of the rgb888 to target pixel format converter
//
//   port group   role        payload
//   req_*        stream in   tdata[23:0]  src_pixel
//   rsp_*        stream out  tdata[31:0]  dst_pixel
//   csr_*        apb slave   eight format registers, 4-byte stride
//
// one pixel per clock while no rebuild runs and the output is not stalled;
// a taken pixel passes the table read, then assembly into the output
// register; the rate is bounded by the one read port of each channel table.
// after reset and after every write to a channel maximum the three
// 256-entry tables are rebuilt in one sweep, during which req_tready
// is low; register writes are taken throughout.
// a stalled result holds the output register, the table read stage keeps
// one more pixel, and only then does req_tready drop.
`include "rgb888_pixel_format_converter_unit_defines.svh"

module rgb888_pixel_format_converter_unit (
   input  logic                        clock,
   input  logic                        reset,
   // src_pixel [23:0]
   input  logic [rpfc_pkg::SRC_W-1:0]  req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // dst_pixel [31:0]
   output logic [rpfc_pkg::PIX_W-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rpfc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rpfc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rpfc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   rpfc_pkg::cfg_type           cfg;
   rpfc_pkg::tbl_wr_type        tbl_wr;
   logic                        max_wr;
   logic                        fill_busy;
   logic                        rd_en;
   logic                        v1_ff, v1_in;
   logic                        pix_ready;
   logic                        s1_move;
   logic [rpfc_pkg::CHAN_W-1:0] red_val, green_val, blue_val;

   // register file
   rpfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .max_wr      (max_wr)
   );

   // table rebuild
   rpfc_fill u_fill (
      .clock  (clock),
      .reset  (reset),
      .max_wr (max_wr),
      .cfg    (cfg),
      .tbl_wr (tbl_wr),
      .busy   (fill_busy)
   );

   // accept while tables are settled and the read stage can move
   assign req_tready = ~fill_busy & (~v1_ff | pix_ready);
   assign rd_en      = req_tvalid & req_tready;
   assign s1_move    = v1_ff & pix_ready;

   // channel scaling tables
   rpfc_ram #(
      .WIDTH (rpfc_pkg::CHAN_W),
      .DEPTH (rpfc_pkg::TBL_DEPTH)
   ) u_red_tbl (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.red),
      .rd_en   (rd_en),
      .rd_addr (req_tdata[23:16]),
      .rd_data (red_val)
   );

   rpfc_ram #(
      .WIDTH (rpfc_pkg::CHAN_W),
      .DEPTH (rpfc_pkg::TBL_DEPTH)
   ) u_green_tbl (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.green),
      .rd_en   (rd_en),
      .rd_addr (req_tdata[15:8]),
      .rd_data (green_val)
   );

   rpfc_ram #(
      .WIDTH (rpfc_pkg::CHAN_W),
      .DEPTH (rpfc_pkg::TBL_DEPTH)
   ) u_blue_tbl (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.blue),
      .rd_en   (rd_en),
      .rd_addr (req_tdata[7:0]),
      .rd_data (blue_val)
   );

   // table read stage valid
   always_comb begin
      v1_in = v1_ff;
      if (rd_en) begin
         v1_in = 1'b1;
      end else if (s1_move) begin
         v1_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   // assembly and output
   rpfc_pixel u_pixel (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v1_ff),
      .in_ready   (pix_ready),
      .red_val    (red_val),
      .green_val  (green_val),
      .blue_val   (blue_val),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // checks
   `ASSERT_IMPLIES(a_no_rw_clash, clock, reset, tbl_wr.en, !rd_en, "table write during pixel read")
   `ASSERT_NEXT(a_max_wr_blocks, clock, reset, max_wr, !req_tready, "input open during rebuild")
   `ASSERT_NEXT(a_stage_holds, clock, reset, v1_ff && !s1_move, v1_ff, "read stage pixel lost")

endmodule
